// ===== hdl/pbch_resource_element_demapper_unit_assert.svh =====
// assertion macros shared by the demapper checker
`ifndef PBCH_RESOURCE_ELEMENT_DEMAPPER_UNIT_ASSERT_SVH
`define PBCH_RESOURCE_ELEMENT_DEMAPPER_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define PBCH_RDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while reset is held
`define PBCH_RDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pbch_rdm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbch_rdm_pkg
// types, constants and helpers of the pbch resource element demapper
// ----------------------------------------------------------------------------
package pbch_rdm_pkg;

    localparam int FFT_SIZE = 512;
    localparam int FFT_BITS = $clog2(FFT_SIZE);
    localparam int CELL_ID_W = 10;

    // band edges, in bins and subcarriers
    localparam logic [8:0] PBCH_HALF       = 9'd120;
    localparam logic [8:0] BAND_HIGH_START = 9'(FFT_SIZE - 120);
    localparam logic [7:0] MID_LOW_END     = 8'd48;
    localparam logic [7:0] MID_HIGH_START  = 8'd192;
    localparam logic [7:0] MID_GAP         = 8'd144;

    // per-symbol list bases
    localparam logic [8:0] DMRS_BASE_SYM1 = 9'd60;
    localparam logic [8:0] DATA_BASE_SYM1 = 9'd180;
    localparam logic [8:0] DMRS_BASE_SYM2 = 9'd84;
    localparam logic [8:0] DATA_BASE_SYM2 = 9'd252;

    // list lengths
    localparam logic [8:0] DMRS_COUNT = 9'd144;
    localparam logic [8:0] DATA_COUNT = 9'd432;

    // symbol codes
    localparam logic [1:0] SYM_FIRST  = 2'd0;
    localparam logic [1:0] SYM_MID    = 2'd1;
    localparam logic [1:0] SYM_THIRD  = 2'd2;
    localparam logic [1:0] SYM_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          symbol;
        logic [8:0]          fft_position;
        logic signed [15:0]  sample_real;
        logic signed [15:0]  sample_imag;
    } t_in_beat;

    typedef struct packed {
        logic                is_dmrs;
        logic [8:0]          out_index;
        logic signed [15:0]  out_real;
        logic signed [15:0]  out_imag;
    } t_out_beat;

    function automatic logic [FFT_BITS-1:0] bit_rev(input logic [FFT_BITS-1:0] x);
        logic [FFT_BITS-1:0] r;
        for (int i = 0; i < FFT_BITS; i++) begin
            r[i] = x[FFT_BITS-1-i];
        end
        return r;
    endfunction

endpackage

// ===== hdl/pbch_rdm_map.sv =====
// ----------------------------------------------------------------------------
// pbch_rdm_map
// maps one registered sample to its dmrs or data list slot
// ----------------------------------------------------------------------------
module pbch_rdm_map (
    input  pbch_rdm_pkg::t_in_beat  i_beat,
    input  logic [1:0]              i_shift,
    output logic                    o_keep,
    output pbch_rdm_pkg::t_out_beat o_beat
);

    logic [8:0] bin;
    logic [7:0] sc;
    logic [7:0] sc_k;
    logic       in_band;
    logic       mid_keep;
    logic       sym_ok;
    logic [8:0] dmrs_base;
    logic [8:0] data_base;
    logic [8:0] before_sum;
    logic [5:0] dmrs_before;
    logic       dmrs;

    always_comb begin
        bin = pbch_rdm_pkg::bit_rev(i_beat.fft_position);

        // upper band edge first, then the low bins after dc
        if (bin >= pbch_rdm_pkg::BAND_HIGH_START) begin
            in_band = 1'b1;
            sc      = 8'(bin - pbch_rdm_pkg::BAND_HIGH_START);
        end else if (bin < pbch_rdm_pkg::PBCH_HALF) begin
            in_band = 1'b1;
            sc      = 8'(bin + pbch_rdm_pkg::PBCH_HALF);
        end else begin
            in_band = 1'b0;
            sc      = 8'd0;
        end

        sc_k     = sc;
        mid_keep = 1'b1;
        sym_ok   = 1'b1;
        unique case (i_beat.symbol)
            pbch_rdm_pkg::SYM_FIRST: begin
                dmrs_base = 9'd0;
                data_base = 9'd0;
            end
            pbch_rdm_pkg::SYM_MID: begin
                dmrs_base = pbch_rdm_pkg::DMRS_BASE_SYM1;
                data_base = pbch_rdm_pkg::DATA_BASE_SYM1;
                // middle symbol: sss occupies the center, close the gap
                if (sc < pbch_rdm_pkg::MID_LOW_END) begin
                    sc_k = sc;
                end else if (sc >= pbch_rdm_pkg::MID_HIGH_START) begin
                    sc_k = sc - pbch_rdm_pkg::MID_GAP;
                end else begin
                    mid_keep = 1'b0;
                end
            end
            pbch_rdm_pkg::SYM_THIRD: begin
                dmrs_base = pbch_rdm_pkg::DMRS_BASE_SYM2;
                data_base = pbch_rdm_pkg::DATA_BASE_SYM2;
            end
            pbch_rdm_pkg::SYM_UNUSED: begin
                dmrs_base = 9'd0;
                data_base = 9'd0;
                sym_ok    = 1'b0;
            end
        endcase

        // dmrs count strictly below sc_k
        before_sum  = {1'b0, sc_k} + 9'd3 - {7'd0, i_shift};
        dmrs_before = 6'(before_sum >> 2);
        dmrs        = (sc_k[1:0] == i_shift);

        o_keep           = in_band && mid_keep && sym_ok;
        o_beat.is_dmrs   = dmrs;
        o_beat.out_index = dmrs ? (dmrs_base + {3'd0, dmrs_before})
                                : (data_base + {1'b0, sc_k - {2'd0, dmrs_before}});
        o_beat.out_real  = i_beat.sample_real;
        o_beat.out_imag  = i_beat.sample_imag;
    end

endmodule

// ===== hdl/pbch_resource_element_demapper_unit.sv =====
// ----------------------------------------------------------------------------
// pbch_resource_element_demapper_unit
// pbch resource element demapper for the ss/pbch block
// ----------------------------------------------------------------------------
// Takes one fft output sample per beat, with its bit-reversed buffer position
// and pbch symbol number, and sends on at most one beat: the sample tagged as
// dmrs or pbch data and indexed in its list (dmrs 0..143, data 0..431).
// Samples outside the pbch band, in the sss gap of the middle symbol or with
// symbol code 3 give no output beat. Throughput is one beat per cycle while
// the output is not stalled; an accepted sample passes through the input
// register, then the mapping logic, then the output register, and is held
// back only while the output is stalled. The cell id register may only be
// written while no beat is in flight; only its value mod 4 is kept.
// ----------------------------------------------------------------------------
module pbch_resource_element_demapper_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [pbch_rdm_pkg::CELL_ID_W-1:0]    i_cfg_data,
    // sample input
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  pbch_rdm_pkg::t_in_beat                i_in_data,
    // demapped output
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output pbch_rdm_pkg::t_out_beat               o_out_data
);

    // dmrs subcarrier shift, cell id mod 4
    logic [1:0]              r_shift;

    // input stage
    logic                    r_s1_valid;
    logic                    n_s1_valid;
    pbch_rdm_pkg::t_in_beat  r_s1_beat;

    // output stage
    logic                    r_out_valid;
    logic                    n_out_valid;
    pbch_rdm_pkg::t_out_beat r_out_beat;

    logic                    map_keep;
    pbch_rdm_pkg::t_out_beat map_beat;
    logic                    out_free;
    logic                    s1_move;
    logic                    in_take;

    pbch_rdm_map u_map (
        .i_beat (r_s1_beat),
        .i_shift(r_shift),
        .o_keep (map_keep),
        .o_beat (map_beat)
    );

    // output register empty or draining this cycle
    assign out_free = !r_out_valid || i_out_ready;
    // the input stage moves on when the output can take it; dropped beats
    // follow the same rule so the stage control stays simple
    assign s1_move  = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_take  = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid = in_take ? 1'b1 : (s1_move ? 1'b0 : r_s1_valid);
        if (out_free) begin
            n_out_valid = s1_move && map_keep;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= 2'd0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_shift <= i_cfg_data[1:0];
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_beat <= i_in_data;
        end
        if (out_free && s1_move) begin
            r_out_beat <= map_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_beat;

endmodule

// ===== hdl/pbch_rdm_checker.sv =====
// ----------------------------------------------------------------------------
// pbch_rdm_checker
// port-level checks of the pbch resource element demapper
// ----------------------------------------------------------------------------
`include "pbch_resource_element_demapper_unit_assert.svh"

module pbch_rdm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input pbch_rdm_pkg::t_out_beat            o_out_data
);

    // stalled output beat holds
    `PBCH_RDM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "output beat changed while stalled")

    // indexes stay inside their lists
    `PBCH_RDM_ASSERT_NOW(a_index_range, o_out_valid, (o_out_data.is_dmrs && o_out_data.out_index < pbch_rdm_pkg::DMRS_COUNT) || (!o_out_data.is_dmrs && o_out_data.out_index < pbch_rdm_pkg::DATA_COUNT), "list index out of range")

    // an empty output never blocks the input
    `PBCH_RDM_ASSERT_NOW(a_ready_free, !o_out_valid, o_in_ready, "input stalled with output empty")

    // a new output beat comes from an accepted input beat
    `PBCH_RDM_ASSERT_NOW(a_latency, $rose(o_out_valid), $past(i_in_valid && o_in_ready, 2), "output beat without matching input beat")

endmodule

bind pbch_resource_element_demapper_unit pbch_rdm_checker u_pbch_rdm_checker (.*);

// ===== dv/pbch_resource_element_demapper_unit_tb.sv =====
// ----------------------------------------------------------------------------
// pbch_resource_element_demapper_unit_tb
// self-checking regression for the pbch resource element demapper
// ----------------------------------------------------------------------------
// Streams fft samples into the demapper under several cell id settings and
// checks every output beat against a demap predictor kept in the bench.
// A short directed set hits the band edges, the gap of the middle symbol and
// the unused symbol code; the rest is random, mostly in-band samples. Both
// sides idle in random bursts, and once the output holds off long enough for
// the block to back up and stall its input.
// ----------------------------------------------------------------------------
module pbch_resource_element_demapper_unit_tb;

    logic                                  i_clk;
    logic                                  i_rst_n    = 1'b0;
    logic                                  i_cfg_we   = 1'b0;
    logic [pbch_rdm_pkg::CELL_ID_W-1:0]    i_cfg_data = '0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_ready;
    pbch_rdm_pkg::t_in_beat                i_in_data  = '0;
    logic                                  o_out_valid;
    logic                                  i_out_ready = 1'b0;
    pbch_rdm_pkg::t_out_beat               o_out_data;

    pbch_resource_element_demapper_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // samples waiting to be offered, and demapped beats still owed by the block
    pbch_rdm_pkg::t_in_beat             sample_q[$];
    pbch_rdm_pkg::t_out_beat            demap_q[$];

    // bench copy of the cell id register
    logic [pbch_rdm_pkg::CELL_ID_W-1:0] cell_shadow = '0;

    int unsigned beats_queued   = 0;
    int unsigned beats_accepted = 0;
    int unsigned beats_out      = 0;
    int unsigned dmrs_seen      = 0;
    int unsigned data_seen      = 0;
    int unsigned cell_settings  = 0;
    int unsigned mismatches     = 0;

    // idling control: percent chance of a burst starting, none in the tail
    int unsigned idle_pct   = 0;
    bit          quiet_tail = 1'b0;

    // long output hold-off to back the block up
    logic        long_hold  = 1'b0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;

    int unsigned send_gap   = 0;
    int unsigned stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard limit, well above the slowest legal run
    initial begin
        #3000000;
        $display("timeout: %0d of %0d samples accepted, %0d beats owed",
                 beats_accepted, beats_queued, demap_q.size());
        $display("pbch_resource_element_demapper_unit regression: fail");
        $finish;
    end

    // fft buffer position holding a given bin: the bit reversal is its own inverse
    function automatic logic [8:0] bin_pos(input int unsigned bin);
        logic [8:0] b;
        b = 9'(bin);
        return {<<{b}};
    endfunction

    // demap predictor: returns 1 and the beat when the sample is kept
    function automatic bit demap_sample(input pbch_rdm_pkg::t_in_beat s,
                                        input logic [pbch_rdm_pkg::CELL_ID_W-1:0] cell_val,
                                        output pbch_rdm_pkg::t_out_beat r);
        logic [8:0]  bin;
        int unsigned sc;
        int unsigned shift;
        int unsigned dmrs_below;
        int unsigned dmrs_base;
        int unsigned data_base;
        bit          is_pilot;
        r = '0;
        if (s.symbol == pbch_rdm_pkg::SYM_UNUSED) begin
            return 1'b0;
        end
        bin = {<<{s.fft_position}};
        // upper 120 bins are the low half of the block, bins 0..119 the high half
        if (bin >= pbch_rdm_pkg::BAND_HIGH_START) begin
            sc = bin - pbch_rdm_pkg::BAND_HIGH_START;
        end else if (bin < pbch_rdm_pkg::PBCH_HALF) begin
            sc = bin + pbch_rdm_pkg::PBCH_HALF;
        end else begin
            return 1'b0;
        end
        case (s.symbol)
            pbch_rdm_pkg::SYM_MID: begin
                // sss sits in the middle of this symbol; the two ends close up
                if (sc >= pbch_rdm_pkg::MID_HIGH_START) begin
                    sc = sc - pbch_rdm_pkg::MID_GAP;
                end else if (sc >= pbch_rdm_pkg::MID_LOW_END) begin
                    return 1'b0;
                end
                dmrs_base = pbch_rdm_pkg::DMRS_BASE_SYM1;
                data_base = pbch_rdm_pkg::DATA_BASE_SYM1;
            end
            pbch_rdm_pkg::SYM_THIRD: begin
                dmrs_base = pbch_rdm_pkg::DMRS_BASE_SYM2;
                data_base = pbch_rdm_pkg::DATA_BASE_SYM2;
            end
            default: begin
                dmrs_base = 0;
                data_base = 0;
            end
        endcase
        shift      = cell_val % 4;
        dmrs_below = (sc + 3 - shift) / 4;
        is_pilot   = (sc % 4) == shift;
        r.is_dmrs   = is_pilot;
        r.out_index = is_pilot ? 9'(dmrs_base + dmrs_below) : 9'(data_base + sc - dmrs_below);
        r.out_real  = s.sample_real;
        r.out_imag  = s.sample_imag;
        return 1'b1;
    endfunction

    // sender: one sample per beat from the pending queue, idling in bursts
    always @(posedge i_clk) begin : drive_samples
        logic                    next_valid;
        pbch_rdm_pkg::t_in_beat  next_beat;
        pbch_rdm_pkg::t_out_beat predicted;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            next_beat  = i_in_data;
            if (i_in_valid && o_in_ready) begin
                beats_accepted++;
                if (demap_sample(i_in_data, cell_shadow, predicted)) begin
                    demap_q.push_back(predicted);
                end
                next_valid = 1'b0;
            end
            // a held beat stays put; otherwise pick the next one or idle
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (sample_q.size() != 0) begin
                    if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
                        send_gap = $urandom_range(0, 13);
                    end else begin
                        next_beat  = sample_q.pop_front();
                        next_valid = 1'b1;
                    end
                end
            end
            i_in_valid <= next_valid;
            i_in_data  <= next_beat;
        end
    end

    // receiver: checks each output beat against the oldest prediction
    always @(posedge i_clk) begin : check_beats
        pbch_rdm_pkg::t_out_beat want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                beats_out++;
                if (demap_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected beat: dmrs %0b index %0d re %0d im %0d",
                                 o_out_data.is_dmrs, o_out_data.out_index,
                                 o_out_data.out_real, o_out_data.out_imag);
                    end
                end else begin
                    want = demap_q.pop_front();
                    if (o_out_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"beat %0d mismatch: want dmrs %0b index %0d re %0d im %0d,",
                                      " got dmrs %0b index %0d re %0d im %0d"},
                                     beats_out, want.is_dmrs, want.out_index,
                                     want.out_real, want.out_imag,
                                     o_out_data.is_dmrs, o_out_data.out_index,
                                     o_out_data.out_real, o_out_data.out_imag);
                        end
                    end else if (want.is_dmrs) begin
                        dmrs_seen++;
                    end else begin
                        data_seen++;
                    end
                end
            end
            // stall in random bursts, or for the whole long hold-off
            if (long_hold) begin
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(0, 13);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // one long hold-off once traffic is well under way, so the block backs up
    always @(posedge i_clk) begin : hold_output
        if (!i_rst_n) begin
            long_hold <= 1'b0;
        end else if (long_hold) begin
            if (hold_left == 0) begin
                long_hold <= 1'b0;
            end else begin
                hold_left--;
            end
        end else if (!hold_done && beats_accepted >= 600) begin
            hold_done = 1'b1;
            hold_left = 250;
            long_hold <= 1'b1;
        end
    end

    task automatic push_raw(input logic [1:0] sym, input logic [8:0] pos,
                            input logic [15:0] re, input logic [15:0] im);
        pbch_rdm_pkg::t_in_beat s;
        s.symbol       = sym;
        s.fft_position = pos;
        s.sample_real  = re;
        s.sample_imag  = im;
        sample_q.push_back(s);
        beats_queued++;
    endtask

    // queue a sample by subcarrier of the 240-wide block
    task automatic push_sc(input logic [1:0] sym, input int unsigned sc,
                           input logic [15:0] re, input logic [15:0] im);
        push_raw(sym, bin_pos(sc < 120 ? sc + 392 : sc - 120), re, im);
    endtask

    // block is idle once every sample is taken and every beat is back;
    // samples with no output may still be in the pipe, so pad before returning
    task automatic wait_drained;
        while (beats_accepted != beats_queued || demap_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cell(input logic [pbch_rdm_pkg::CELL_ID_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        cell_shadow = value;
        cell_settings++;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // random traffic until the given number of kept samples is queued;
    // three in four are in-band, the rest any position and any symbol code
    task automatic push_random(input int unsigned kept_target);
        int unsigned             kept;
        pbch_rdm_pkg::t_in_beat  s;
        pbch_rdm_pkg::t_out_beat scratch;
        kept = 0;
        while (kept < kept_target) begin
            if ($urandom_range(0, 3) != 0) begin
                s.symbol       = 2'($urandom_range(0, 2));
                s.fft_position = bin_pos($urandom_range(0, 239) < 120 ?
                                         $urandom_range(392, 511) : $urandom_range(0, 119));
            end else begin
                s.symbol       = 2'($urandom_range(0, 3));
                s.fft_position = 9'($urandom_range(0, 511));
            end
            s.sample_real = 16'($urandom);
            s.sample_imag = 16'($urandom);
            push_raw(s.symbol, s.fft_position, s.sample_real, s.sample_imag);
            if (demap_sample(s, cell_shadow, scratch)) begin
                kept++;
            end
        end
    endtask

    initial begin : run_phases
        logic [pbch_rdm_pkg::CELL_ID_W-1:0] cells[6];
        int unsigned                        densities[6];
        cells     = '{10'd1007, 10'd1, 10'd1023, 10'd2, 10'($urandom_range(0, 1007)), 10'd3};
        densities = '{15, 30, 10, 0, 40, 0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: band edges, out-of-band bins, middle-symbol gap, unused code
        write_cell(10'd0);
        idle_pct = 20;
        push_sc(pbch_rdm_pkg::SYM_FIRST, 0,   16'sh7fff, 16'sh8000);
        push_sc(pbch_rdm_pkg::SYM_FIRST, 119, 16'sh8000, 16'sh7fff);
        push_sc(pbch_rdm_pkg::SYM_FIRST, 120, 16'sh0000, 16'sh0000);
        push_sc(pbch_rdm_pkg::SYM_FIRST, 239, 16'shffff, 16'shffff);
        push_raw(pbch_rdm_pkg::SYM_FIRST, bin_pos(120), 16'sh1234, 16'sh4321);
        push_raw(pbch_rdm_pkg::SYM_FIRST, bin_pos(391), 16'sh1111, 16'sh2222);
        push_raw(pbch_rdm_pkg::SYM_FIRST, 9'd0,   16'sh0001, 16'shfffe);
        push_raw(pbch_rdm_pkg::SYM_FIRST, 9'd511, 16'sh5555, 16'shaaaa);
        push_sc(pbch_rdm_pkg::SYM_THIRD, 0,   16'sh7fff, 16'sh7fff);
        push_sc(pbch_rdm_pkg::SYM_THIRD, 3,   16'sh8000, 16'sh8000);
        push_sc(pbch_rdm_pkg::SYM_THIRD, 239, 16'sh0a0a, 16'sha0a0);
        push_sc(pbch_rdm_pkg::SYM_MID, 0,   16'sh0102, 16'sh0304);
        push_sc(pbch_rdm_pkg::SYM_MID, 47,  16'sh0506, 16'sh0708);
        push_sc(pbch_rdm_pkg::SYM_MID, 48,  16'sh090a, 16'sh0b0c);
        push_sc(pbch_rdm_pkg::SYM_MID, 191, 16'sh0d0e, 16'sh0f10);
        push_sc(pbch_rdm_pkg::SYM_MID, 192, 16'sh1112, 16'sh1314);
        push_sc(pbch_rdm_pkg::SYM_MID, 239, 16'sh1516, 16'sh1718);
        push_sc(pbch_rdm_pkg::SYM_UNUSED, 0,   16'sh7fff, 16'sh8000);
        push_raw(pbch_rdm_pkg::SYM_UNUSED, 9'd511, 16'sh8000, 16'sh7fff);
        push_sc(pbch_rdm_pkg::SYM_FIRST, 1, 16'sh8000, 16'sh0000);
        push_sc(pbch_rdm_pkg::SYM_FIRST, 2, 16'sh0000, 16'sh8000);
        push_random(40);
        wait_drained();

        // random phases, one per cell id; the last one runs without idling
        for (int p = 0; p < 6; p++) begin
            write_cell(cells[p]);
            idle_pct   = densities[p];
            quiet_tail = (p == 5);
            push_random(210);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("covered %0d samples over %0d cell id settings: %0d dmrs and %0d data beats",
                 beats_accepted, cell_settings, dmrs_seen, data_seen);
        $display("band edges, middle-symbol gap, unused symbol code and a long output stall included");
        if (mismatches == 0 && demap_q.size() == 0) begin
            $display("pbch_resource_element_demapper_unit regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("pbch_resource_element_demapper_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pbch_rdm_pkg.sv
hdl/pbch_rdm_map.sv
hdl/pbch_resource_element_demapper_unit.sv
hdl/pbch_rdm_checker.sv
dv/pbch_resource_element_demapper_unit_tb.sv
